/* src/eet_pkg.sv */
// Types and constants shared by the extended Euclidean table block.
package eet_pkg;

	localparam int COEF_W    = 32;
	localparam int REM_W     = 31;
	localparam int OPND_W    = 32;
	localparam int MAX_ROWS  = 48;
	localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

	typedef struct packed {
		logic signed [OPND_W-1:0] value_a;
		logic signed [OPND_W-1:0] value_b;
	} operands_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_x;
		logic signed [COEF_W-1:0] coef_y;
		logic        [REM_W-1:0]  remainder;
		logic        [REM_W-1:0]  quotient;
		logic                     last_row;
		logic        [REM_W-1:0]  gcd_value;
		logic signed [COEF_W-1:0] bezout_x;
		logic signed [COEF_W-1:0] bezout_y;
	} row_t;

endpackage

/* src/eet_divider.sv */
// Restoring divider, one quotient bit per cycle through a shared subtractor.
module eet_divider #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder
);

	localparam int CntW = $clog2(DATA_WIDTH + 1);

	logic                  running_q;
	logic                  done_q;
	logic [CntW-1:0]       cnt_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] div_q;
	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH:0]   diff;

	assign shifted = {acc_q, quo_q[DATA_WIDTH-1]};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= CntW'(DATA_WIDTH);
				acc_q     <= '0;
				quo_q     <= dividend;
				div_q     <= divisor;
			end else if (running_q) begin
				if (!diff[DATA_WIDTH]) begin
					acc_q <= diff[DATA_WIDTH-1:0];
					quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
				end else begin
					acc_q <= shifted[DATA_WIDTH-1:0];
					quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = acc_q;

endmodule

/* src/extended_euclid_table.sv */
// Extended Euclidean table: one operand pair in, the table rows out in order.
// The first row is loaded in ST_ROW1 once the operands are taken, the second in ST_EMIT.
// Each further row passes through the bit-serial divider (ST_DIV), the shared multiplier
// (ST_MULX, ST_MULY), an update step (ST_UPD) and an emit step (ST_EMIT).
// A table has at most 46 rows at DATA_WIDTH 32; the row counter caps it at MAX_ROWS.
// arst_n clears the sequencer and the output valid; the block then waits idle.
module extended_euclid_table
	import eet_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      operands_valid,
	output logic      operands_stall,
	input  operands_t operands,
	output logic      row_valid,
	input  logic      row_stall,
	output row_t      row
);

	localparam int MagW = (DATA_WIDTH > OPND_W + 1) ? DATA_WIDTH : OPND_W + 1;
	localparam logic [MagW-1:0] SAT = (MagW'(1) << (DATA_WIDTH - 1)) - MagW'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW1,
		ST_EMIT,
		ST_DIV,
		ST_MULX,
		ST_MULY,
		ST_UPD
	} state_t;

	state_t                 state_q;
	logic                   row_valid_q;
	row_t                   row_q;
	logic [ROW_CNT_W-1:0]   rows_q;
	logic [COEF_W-1:0]      prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic [DATA_WIDTH-1:0]  prev_rem_q, cur_rem_q, nr_q, q_q;
	logic [COEF_W-1:0]      nx_q, prod_q;

	logic [OPND_W:0]        mag_a_raw, mag_b_raw;
	logic [MagW-1:0]        mag_a_w, mag_b_w;
	logic [DATA_WIDTH-1:0]  mag_a, mag_b, hi, lo;
	logic                   slot_free, cur_zero, more, row_load;
	logic [MagW-1:0]        cur_rem_ext, prev_rem_ext, q_ext;
	logic [COEF_W-1:0]      mul_a;
	logic [2*COEF_W-1:0]    mul_full;
	row_t                   row_next;
	logic                   div_start, div_done;
	logic [DATA_WIDTH-1:0]  div_quo, div_rem;

	always_comb begin
		mag_a_raw = operands.value_a[OPND_W-1]
			? ((OPND_W+1)'(1) << OPND_W) - {1'b0, operands.value_a}
			: {1'b0, operands.value_a};
		mag_b_raw = operands.value_b[OPND_W-1]
			? ((OPND_W+1)'(1) << OPND_W) - {1'b0, operands.value_b}
			: {1'b0, operands.value_b};
		mag_a_w = MagW'(mag_a_raw);
		mag_b_w = MagW'(mag_b_raw);
		if (mag_a_w > SAT) begin
			mag_a_w = SAT;
		end
		if (mag_b_w > SAT) begin
			mag_b_w = SAT;
		end
		mag_a = mag_a_w[DATA_WIDTH-1:0];
		mag_b = mag_b_w[DATA_WIDTH-1:0];
		hi    = (mag_a > mag_b) ? mag_a : mag_b;
		lo    = (mag_a > mag_b) ? mag_b : mag_a;
	end

	assign slot_free    = !row_valid_q || !row_stall;
	assign row_load     = (state_q inside {ST_ROW1, ST_EMIT}) && slot_free;
	assign cur_zero     = (cur_rem_q == '0);
	assign more         = !cur_zero && ((rows_q + ROW_CNT_W'(1)) < ROW_CNT_W'(MAX_ROWS));
	assign cur_rem_ext  = MagW'(cur_rem_q);
	assign prev_rem_ext = MagW'(prev_rem_q);
	assign q_ext        = MagW'(q_q);

	assign mul_a    = (state_q == ST_MULX) ? cur_x_q : cur_y_q;
	assign mul_full = mul_a * q_ext[COEF_W-1:0];

	always_comb begin
		if (state_q == ST_ROW1) begin
			row_next.coef_x    = prev_x_q;
			row_next.coef_y    = prev_y_q;
			row_next.remainder = prev_rem_ext[REM_W-1:0];
			row_next.quotient  = '0;
			row_next.last_row  = 1'b0;
			row_next.gcd_value = '0;
			row_next.bezout_x  = '0;
			row_next.bezout_y  = '0;
		end else begin
			row_next.coef_x    = cur_x_q;
			row_next.coef_y    = cur_y_q;
			row_next.remainder = cur_rem_ext[REM_W-1:0];
			row_next.quotient  = q_ext[REM_W-1:0];
			row_next.last_row  = cur_zero;
			row_next.gcd_value = cur_zero ? prev_rem_ext[REM_W-1:0] : '0;
			row_next.bezout_x  = cur_zero ? prev_x_q : '0;
			row_next.bezout_y  = cur_zero ? prev_y_q : '0;
		end
	end

	assign div_start = (state_q == ST_EMIT) && slot_free && more;

	eet_divider #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prev_rem_q),
		.divisor  (cur_rem_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_valid_q <= 1'b0;
			rows_q      <= '0;
		end else begin
			if (row_load) begin
				row_valid_q <= 1'b1;
			end else if (!row_stall) begin
				row_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (operands_valid) begin
						prev_x_q   <= COEF_W'(1);
						prev_y_q   <= '0;
						prev_rem_q <= hi;
						cur_x_q    <= '0;
						cur_y_q    <= COEF_W'(1);
						cur_rem_q  <= lo;
						q_q        <= '0;
						rows_q     <= '0;
						state_q    <= ST_ROW1;
					end
				end
				ST_ROW1: begin
					if (slot_free) begin
						row_q   <= row_next;
						rows_q  <= rows_q + ROW_CNT_W'(1);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						row_q   <= row_next;
						rows_q  <= rows_q + ROW_CNT_W'(1);
						state_q <= more ? ST_DIV : ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						q_q     <= div_quo;
						nr_q    <= div_rem;
						state_q <= ST_MULX;
					end
				end
				ST_MULX: begin
					prod_q  <= mul_full[COEF_W-1:0];
					state_q <= ST_MULY;
				end
				ST_MULY: begin
					nx_q    <= prev_x_q - prod_q;
					prod_q  <= mul_full[COEF_W-1:0];
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					prev_x_q   <= cur_x_q;
					prev_y_q   <= cur_y_q;
					prev_rem_q <= cur_rem_q;
					cur_x_q    <= nx_q;
					cur_y_q    <= prev_y_q - prod_q;
					cur_rem_q  <= nr_q;
					state_q    <= ST_EMIT;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign operands_stall = (state_q != ST_IDLE);
	assign row_valid      = row_valid_q;
	assign row            = row_q;

endmodule

/* src/eet_checker.sv */
// Port-level checks for the extended Euclidean table, bound to the top level.
module eet_checker
	import eet_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      operands_valid,
	input logic      operands_stall,
	input operands_t operands,
	input logic      row_valid,
	input logic      row_stall,
	input row_t      row
);

	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_stall |=> row_valid && $stable(row))
		else $error("stalled row changed or dropped");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		operands_valid && !operands_stall |=> operands_stall)
		else $error("operands taken but block not busy");

	a_last_zero_rem: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row.last_row |-> row.remainder == '0)
		else $error("last row with nonzero remainder");

	a_summary_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row.last_row |->
			row.gcd_value == '0 && row.bezout_x == '0 && row.bezout_y == '0)
		else $error("gcd or Bezout fields set on an inner row");

endmodule

bind extended_euclid_table eet_checker u_eet_checker (.*);
